### src/stil_pkg.sv
// Shared types, constants and codes for the sorted timestamp insertion list.
package stil_pkg;

   // Table size and derived index widths
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Valid key ranges (signed input fields)
   localparam logic signed [7:0] MONTH_MAX  = 8'sd12;
   localparam logic signed [7:0] DAY_MAX    = 8'sd31;
   localparam logic signed [7:0] HOUR_MAX   = 8'sd24;
   localparam logic signed [7:0] MINUTE_MAX = 8'sd59;

   // Result status codes
   localparam logic [1:0] ST_ACCEPT  = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_LISTED  = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   // Command kinds handed from front to back
   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_INVALID = 2'd1;
   localparam logic [1:0] CMD_DRAIN   = 2'd2;

   // One stored entry; month..minute concatenated form the sort key
   typedef struct packed {
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] tag;
      logic        has_msg;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam int KEY_W   = 20;

   typedef struct packed {
      logic [1:0] kind;
      entry_type  entry;
   } cmd_type;

   function automatic logic [KEY_W-1:0] key_of(input entry_type e);
      key_of = {e.month, e.day, e.hour, e.minute};
   endfunction

endpackage

### src/stil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/stil_front.sv
// Front end: checks an incoming transaction and turns it into a command.
module stil_front
   import stil_pkg::*;
(
   input  logic signed [7:0] month,
   input  logic signed [7:0] day,
   input  logic signed [7:0] hour,
   input  logic signed [7:0] minute,
   input  logic [15:0]       message_tag,
   input  logic              has_message,
   output cmd_type           cmd
);

   logic end_of_input;
   logic bad_key;

   // month zero ends input; any field out of range is rejected
   assign end_of_input = (month == 8'sd0);
   assign bad_key = (month < 8'sd0) || (month > MONTH_MAX) ||
                    (day < 8'sd0) || (day > DAY_MAX) ||
                    (hour < 8'sd0) || (hour > HOUR_MAX) ||
                    (minute < 8'sd0) || (minute > MINUTE_MAX);

   always_comb begin
      if (end_of_input) begin
         cmd.kind = CMD_DRAIN;
      end else if (bad_key) begin
         cmd.kind = CMD_INVALID;
      end else begin
         cmd.kind = CMD_INSERT;
      end
      cmd.entry.month   = month[3:0];
      cmd.entry.day     = day[4:0];
      cmd.entry.hour    = hour[4:0];
      cmd.entry.minute  = minute[5:0];
      cmd.entry.tag     = message_tag;
      cmd.entry.has_msg = has_message;
   end

endmodule

### src/stil_cmdq.sv
// Short command queue between the front end and the table engine.
module stil_cmdq
   import stil_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   cmd_type                slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (fill_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign valid    = (fill_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/stil_back.sv
// Table engine: sorted insert by top-down shift, drain in key order, result register.
module stil_back
   import stil_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [15:0] rsp_out_tag,
   output logic        rsp_last
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS_CMP = 3'd1;
   localparam logic [2:0] S_INS_PUT = 3'd2;
   localparam logic [2:0] S_INS_ACK = 3'd3;
   localparam logic [2:0] S_DR_EMIT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   entry_type         new_ff, new_in;

   // table memory ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type         rd_entry;

   // result register
   logic              out_valid_ff;
   logic [1:0]        out_status_ff;
   entry_type         out_entry_ff;
   logic              out_last_ff;
   logic              out_free;
   logic              load;
   logic [1:0]        ld_status;
   entry_type         ld_entry;
   logic              ld_last;

   logic              goes_before;
   logic              drain_last;

   stil_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);
   assign out_free = !out_valid_ff || rsp_pop;

   // stored entry moves up when the new one sorts before it
   assign goes_before = (key_of(rd_entry) > key_of(new_ff)) ||
                        ((key_of(rd_entry) == key_of(new_ff)) && rd_entry.has_msg);
   assign drain_last  = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      j_in      = j_ff;
      i_in      = i_ff;
      new_in    = new_ff;
      cmd_pop   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = j_ff;
      ram_wdata = new_ff;
      ram_re    = 1'b0;
      ram_raddr = '0;
      load      = 1'b0;
      ld_status = ST_ACCEPT;
      ld_entry  = '0;
      ld_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_INSERT: begin
                     cmd_pop = 1'b1;
                     new_in  = cmd.entry;
                     if (count_ff == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = cmd.entry;
                        state_in  = S_INS_ACK;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = count_ff[ADDR_W-1:0] - ADDR_W'(1);
                        j_in      = count_ff[ADDR_W-1:0];
                        state_in  = S_INS_CMP;
                     end
                  end
                  CMD_DRAIN: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           cmd_pop   = 1'b1;
                           load      = 1'b1;
                           ld_status = ST_EMPTY;
                        end
                     end else begin
                        cmd_pop   = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        i_in      = '0;
                        state_in  = S_DR_EMIT;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        load      = 1'b1;
                        ld_status = ST_INVALID;
                     end
                  end
               endcase
            end
         end
         S_INS_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if (goes_before) begin
               ram_wdata = rd_entry;
               if (j_ff == ADDR_W'(1)) begin
                  j_in     = '0;
                  state_in = S_INS_PUT;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = j_ff - ADDR_W'(2);
                  j_in      = j_ff - ADDR_W'(1);
               end
            end else begin
               ram_wdata = new_ff;
               state_in  = S_INS_ACK;
            end
         end
         S_INS_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = new_ff;
            state_in  = S_INS_ACK;
         end
         S_INS_ACK: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = ST_ACCEPT;
               count_in  = count_ff + CNT_W'(1);
               if (count_ff == CNT_W'(CAPACITY - 1)) begin
                  // table filled: list it right away
                  ld_last   = 1'b0;
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  i_in      = '0;
                  state_in  = S_DR_EMIT;
               end else begin
                  state_in  = S_IDLE;
               end
            end
         end
         S_DR_EMIT: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = ST_LISTED;
               ld_entry  = rd_entry;
               ld_last   = drain_last;
               if (drain_last) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = i_ff + ADDR_W'(1);
                  i_in      = i_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      i_ff   <= i_in;
      new_ff <= new_in;
   end

   // result register: refills in the cycle the old transaction leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_status_ff <= ld_status;
         out_entry_ff  <= ld_entry;
         out_last_ff   <= ld_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_out_month  = out_entry_ff.month;
   assign rsp_out_day    = out_entry_ff.day;
   assign rsp_out_hour   = out_entry_ff.hour;
   assign rsp_out_minute = out_entry_ff.minute;
   assign rsp_out_tag    = out_entry_ff.tag;
   assign rsp_last       = out_last_ff;

`ifndef SYNTH
   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |-> !load)
      else $error("result register overwritten");

   // shift never reads the slot it writes in the same cycle
   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re |-> ram_waddr != ram_raddr)
      else $error("table read and write collide");

   // compare step always has a lower neighbor to look at
   a_cmp_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_CMP |-> j_ff != '0)
      else $error("compare step at slot zero");

   // full count only exists while the table is being listed
   a_full_drains: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(CAPACITY) |-> state_ff == S_DR_EMIT)
      else $error("full table not draining");
`endif

endmodule

### src/sorted_timestamp_insert_list.sv
// Top level of the sorted timestamp insertion list.
//
//   channel   direction  handshake         payload
//   req_      in         push / full       month, day, hour, minute, message_tag, has_message
//   rsp_      out        pop / empty       status, out_month..out_tag, last
//
// For an insert the back end walks the table from the top,
// moving one entry up per cycle through the single write port of the table RAM.
// A drain lists one entry per cycle whenever the result register is free, after a read
// start; invalid and empty-list transactions give one result each. Commands wait in a
// two-deep queue, so req_full rises only when the back end is busy and the queue is full.
// Reset clears the fill count and control state; table contents are not cleared.
// A stalled rsp_pop holds the back end; a stalled back end holds req_full.
module sorted_timestamp_insert_list
   import stil_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic signed [7:0] req_month,
   input  logic signed [7:0] req_day,
   input  logic signed [7:0] req_hour,
   input  logic signed [7:0] req_minute,
   input  logic [15:0]       req_message_tag,
   input  logic              req_has_message,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_status,
   output logic [3:0]        rsp_out_month,
   output logic [4:0]        rsp_out_day,
   output logic [4:0]        rsp_out_hour,
   output logic [5:0]        rsp_out_minute,
   output logic [15:0]       rsp_out_tag,
   output logic              rsp_last
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    head_valid;
   logic    head_pop;
   logic    rsp_valid;

   stil_front u_front (
      .month       (req_month),
      .day         (req_day),
      .hour        (req_hour),
      .minute      (req_minute),
      .message_tag (req_message_tag),
      .has_message (req_has_message),
      .cmd         (front_cmd)
   );

   stil_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_cmd (front_cmd),
      .full     (req_full),
      .valid    (head_valid),
      .head_cmd (head_cmd),
      .pop      (head_pop)
   );

   stil_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (head_valid),
      .cmd            (head_cmd),
      .cmd_pop        (head_pop),
      .rsp_valid      (rsp_valid),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_out_month  (rsp_out_month),
      .rsp_out_day    (rsp_out_day),
      .rsp_out_hour   (rsp_out_hour),
      .rsp_out_minute (rsp_out_minute),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_last       (rsp_last)
   );

   assign rsp_empty = !rsp_valid;

endmodule

### sim/testbench.sv
// Self-checking testbench for the sorted timestamp insertion list.
`timescale 1ns / 1ps

module testbench
   import stil_pkg::*;
();

   localparam int SEND_ITEMS  = 330;
   localparam int TAIL_ITEMS  = 40;
   localparam int LONG_HOLD   = 400;
   localparam int HOLD_AFTER  = 50;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 60;

   // One reminder entry as sent; a pause marker makes the sender wait for quiet
   typedef struct {
      logic signed [7:0] month;
      logic signed [7:0] day;
      logic signed [7:0] hour;
      logic signed [7:0] minute;
      logic [15:0]       tag;
      logic              has_msg;
      bit                pause;
   } reminder_item;

   // One listing line as the block should produce it
   typedef struct {
      logic [1:0]  status;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] tag;
      logic        last;
   } listing;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic signed [7:0] req_month = '0;
   logic signed [7:0] req_day = '0;
   logic signed [7:0] req_hour = '0;
   logic signed [7:0] req_minute = '0;
   logic [15:0]       req_message_tag = '0;
   logic              req_has_message = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [1:0]        rsp_status;
   logic [3:0]        rsp_out_month;
   logic [4:0]        rsp_out_day;
   logic [4:0]        rsp_out_hour;
   logic [5:0]        rsp_out_minute;
   logic [15:0]       rsp_out_tag;
   logic              rsp_last;

   reminder_item pending_items[$];
   listing       due_listings[$];
   entry_type    sorted_slots[CAPACITY];
   int           slot_count = 0;
   int           mismatch_count = 0;
   int           stall_cycles = 0;
   int           item_total = 0;

   sorted_timestamp_insert_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_hour        (req_hour),
      .req_minute      (req_minute),
      .req_message_tag (req_message_tag),
      .req_has_message (req_has_message),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_hour    (rsp_out_hour),
      .rsp_out_minute  (rsp_out_minute),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_last        (rsp_last)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // Queue one expected listing line; only listed entries carry a key and tag
   function automatic void push_listing(input logic [1:0] status, input entry_type e,
                                        input logic last);
      listing l;
      l = '{status: status, month: '0, day: '0, hour: '0, minute: '0, tag: '0, last: last};
      if (status == ST_LISTED) begin
         l.month  = e.month;
         l.day    = e.day;
         l.hour   = e.hour;
         l.minute = e.minute;
         l.tag    = e.tag;
      end
      due_listings.push_back(l);
   endfunction

   // Dump the whole table in key order and clear it
   function automatic void list_all();
      for (int i = 0; i < slot_count; i++)
         push_listing(ST_LISTED, sorted_slots[i], i + 1 == slot_count);
      slot_count = 0;
   endfunction

   // Apply one accepted entry to the shadow table and queue what it produces
   function automatic void file_reminder(input reminder_item it);
      int          m, d, h, mi, pos;
      logic [19:0] key, slot_key;
      entry_type   e;
      m  = it.month;
      d  = it.day;
      h  = it.hour;
      mi = it.minute;
      if (m == 0) begin
         if (slot_count == 0) push_listing(ST_EMPTY, '0, 1'b1);
         else list_all();
      end else if (m < 0 || m > MONTH_MAX || d < 0 || d > DAY_MAX || h < 0 || h > HOUR_MAX ||
                   mi < 0 || mi > MINUTE_MAX) begin
         push_listing(ST_INVALID, '0, 1'b1);
      end else begin
         key = {it.month[3:0], it.day[4:0], it.hour[4:0], it.minute[5:0]};
         if (slot_count > CAPACITY - 1) slot_count = CAPACITY - 1;
         // new entry goes ahead of equal keys carrying a message, behind those without
         pos = 0;
         while (pos < slot_count) begin
            e = sorted_slots[pos];
            slot_key = {e.month, e.day, e.hour, e.minute};
            if (key < slot_key || (key == slot_key && e.has_msg)) break;
            pos++;
         end
         for (int j = slot_count; j > pos; j--) sorted_slots[j] = sorted_slots[j - 1];
         e.month   = it.month[3:0];
         e.day     = it.day[4:0];
         e.hour    = it.hour[4:0];
         e.minute  = it.minute[5:0];
         e.tag     = it.tag;
         e.has_msg = it.has_msg;
         sorted_slots[pos] = e;
         slot_count++;
         if (slot_count >= CAPACITY) begin
            push_listing(ST_ACCEPT, '0, 1'b0);
            list_all();
         end else begin
            push_listing(ST_ACCEPT, '0, 1'b1);
         end
      end
   endfunction

   // Stimulus builders
   function automatic reminder_item mk(input int m, input int d, input int h, input int mi,
                                       input int tag, input bit hm);
      reminder_item it;
      it = '{month: 8'(m), day: 8'(d), hour: 8'(h), minute: 8'(mi), tag: 16'(tag),
             has_msg: hm, pause: 1'b0};
      return it;
   endfunction

   function automatic void add_item(input reminder_item it);
      pending_items.push_back(it);
      if (!it.pause) item_total++;
   endfunction

   function automatic reminder_item random_valid();
      return mk($urandom_range(1, 12), $urandom_range(0, 31), $urandom_range(0, 24),
                $urandom_range(0, 59), $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
   endfunction

   // Out-of-range value for a field whose valid range ends at top
   function automatic int bad_value(input int top);
      if ($urandom_range(0, 1)) return -int'($urandom_range(1, 9));
      return $urandom_range(top + 1, 99);
   endfunction

   function automatic reminder_item random_invalid();
      reminder_item it;
      it = random_valid();
      case ($urandom_range(0, 3))
         0: it.month = 8'(bad_value(int'(MONTH_MAX)));
         1: it.day = 8'(bad_value(int'(DAY_MAX)));
         2: it.hour = 8'(bad_value(int'(HOUR_MAX)));
         default: it.minute = 8'(bad_value(int'(MINUTE_MAX)));
      endcase
      return it;
   endfunction

   function automatic reminder_item random_noise();
      return mk(int'($urandom_range(0, 108)) - 9, int'($urandom_range(0, 108)) - 9,
                int'($urandom_range(0, 108)) - 9, int'($urandom_range(0, 108)) - 9,
                $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
   endfunction

   // Idle-cycle watchdog: counts cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   // Driver: presents pending entries, predicts each accepted one
   always @(posedge clock) begin : driver_proc
      logic         drive_push;
      reminder_item cur_item;
      int           send_gap;
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         drive_push = req_push;
         if (req_push && !req_full) begin
            file_reminder(cur_item);
            drive_push = 1'b0;
         end
         if (!drive_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_items.size() > 0) begin
               if (pending_items[0].pause) begin
                  // hold back until every outstanding result has been popped
                  if (due_listings.size() == 0) void'(pending_items.pop_front());
               end else if (pending_items.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 9) - 1;
               end else begin
                  cur_item = pending_items.pop_front();
                  req_month       <= cur_item.month;
                  req_day         <= cur_item.day;
                  req_hour        <= cur_item.hour;
                  req_minute      <= cur_item.minute;
                  req_message_tag <= cur_item.tag;
                  req_has_message <= cur_item.has_msg;
                  drive_push = 1'b1;
               end
            end
         end
         req_push <= drive_push;
      end
   end

   // Monitor: pops results, compares with the oldest expected listing
   always @(posedge clock) begin : monitor_proc
      logic   take;
      listing want;
      int     hold_left;
      int     results_seen;
      bit     long_hold_done;
      if (reset) begin
         rsp_pop <= 1'b0;
         hold_left = 0;
         results_seen = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_listings.size() == 0) begin
               report_mismatch($sformatf("unexpected result with status %0d", rsp_status));
            end else begin
               want = due_listings.pop_front();
               check_field("status", int'(rsp_status), int'(want.status));
               check_field("month", int'(rsp_out_month), int'(want.month));
               check_field("day", int'(rsp_out_day), int'(want.day));
               check_field("hour", int'(rsp_out_hour), int'(want.hour));
               check_field("minute", int'(rsp_out_minute), int'(want.minute));
               check_field("tag", int'(rsp_out_tag), int'(want.tag));
               check_field("last", int'(rsp_last), int'(want.last));
            end
            results_seen++;
         end
         // one long hold-off to back the block up, plus short random stalls
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            take = 1'b0;
         end else if (pending_items.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 9) - 1;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_pop <= take;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      reminder_item pool[4];
      int           run_len;
      bit           paused_mid;
      bit           timed_out;

      // directed: empty drain, every invalid field both ways, key extremes, tie order
      add_item(mk(0, 0, 0, 0, 16'h0000, 1'b0));
      add_item(mk(-1, 5, 5, 5, 16'h1111, 1'b1));
      add_item(mk(13, 5, 5, 5, 16'h1112, 1'b0));
      add_item(mk(-9, 5, 5, 5, 16'h1113, 1'b1));
      add_item(mk(99, 5, 5, 5, 16'h1114, 1'b0));
      add_item(mk(3, -1, 5, 5, 16'h1115, 1'b1));
      add_item(mk(3, 32, 5, 5, 16'h1116, 1'b0));
      add_item(mk(3, 4, 25, 5, 16'h1117, 1'b1));
      add_item(mk(3, 4, -9, 5, 16'h1118, 1'b0));
      add_item(mk(3, 4, 5, 60, 16'h1119, 1'b1));
      add_item(mk(3, 4, 5, -1, 16'h111A, 1'b0));
      add_item(mk(1, 0, 0, 0, 16'hFFFF, 1'b1));
      add_item(mk(12, 31, 24, 59, 16'h0000, 1'b0));
      add_item(mk(6, 15, 12, 30, 16'hA001, 1'b0));
      add_item(mk(6, 15, 12, 30, 16'hA002, 1'b1));
      add_item(mk(6, 15, 12, 30, 16'hA003, 1'b0));
      add_item(mk(6, 15, 12, 30, 16'hA004, 1'b1));
      add_item(mk(1, 0, 0, 0, 16'h5555, 1'b0));
      add_item(mk(0, 99, -9, 77, 16'hAAAA, 1'b1));
      add_item(mk(0, 0, 0, 0, 16'h0000, 1'b0));

      // random: mostly insert runs ending in a drain, some long enough to fill the table
      paused_mid = 1'b0;
      while (item_total < SEND_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            foreach (pool[i]) pool[i] = random_valid();
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 38)
                                                  : $urandom_range(1, 10);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  add_item(random_invalid());
               end else if ($urandom_range(0, 9) < 4) begin
                  pool[$urandom_range(0, 3)].tag = 16'($urandom_range(0, 65535));
                  pool[$urandom_range(0, 3)].has_msg = 1'($urandom_range(0, 1));
                  add_item(pool[$urandom_range(0, 3)]);
               end else begin
                  add_item(random_valid());
               end
            end
            if ($urandom_range(0, 4) != 0) add_item(mk(0, 0, 0, 0, 0, 1'b0));
         end else begin
            repeat ($urandom_range(1, 4)) add_item(random_noise());
         end
         if (!paused_mid && item_total >= SEND_ITEMS / 2) begin
            reminder_item marker;
            marker = mk(0, 0, 0, 0, 0, 1'b0);
            marker.pause = 1'b1;
            add_item(marker);
            paused_mid = 1'b1;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // wait for all entries to go in and all results to come out
      timed_out = 1'b0;
      while (!(pending_items.size() == 0 && !req_push && due_listings.size() == 0)) begin
         @(negedge clock);
         if (stall_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
      end
      if (!timed_out) repeat (SETTLE) @(negedge clock);
      if (due_listings.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", due_listings.size()));

      if (!timed_out && mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
src/stil_pkg.sv
src/stil_ram.sv
src/stil_front.sv
src/stil_cmdq.sv
src/stil_back.sv
src/sorted_timestamp_insert_list.sv
sim/testbench.sv
